// ----- hw/rtl/pap_pkg.sv -----
// ----------------------------------------------------------------------------
// pap_pkg
// Shared widths, defaults and the sequencer state type for the polygon
// area / perimeter block.
// ----------------------------------------------------------------------------
package pap_pkg;

  // vertex coordinate width, fixed by the port fields
  localparam int COORD_W  = 16;
  // vertex differences need one more bit
  localparam int DIFF_W   = COORD_W + 1;
  // sum of two products of differences
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int AREA_W   = 45;
  localparam int PERIM_W  = 35;

  localparam int FRAC_BITS_DEF    = 8;
  localparam int MAX_VERTICES_DEF = 1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_MUL,
    ST_EDGE_ROOT,
    ST_CLOSE_START,
    ST_CLOSE_MUL,
    ST_CLOSE_ROOT,
    ST_DONE
  } pap_state_t;

endpackage

// ----- hw/rtl/polygon_area_perimeter.sv -----
// ----------------------------------------------------------------------------
// polygon_area_perimeter
// Streams polygon vertices and returns twice the signed shoelace area and the
// fixed-point perimeter on the vertex flagged last.
// ----------------------------------------------------------------------------
// One vertex is taken at a time; in_stall stays high while it is worked on.
// Each edge goes through a pair of bit-serial multipliers (edge length squared
// and the fan cross product, COORD_W+1 steps) and then a bit-serial square
// root (COORD_W+1+FRAC_BITS steps). The first vertex of a polygon, and
// vertices beyond MAX_VERTICES (which are dropped), start no edge and, unless
// flagged last, leave the input free. The last vertex then runs the closing
// edge through the squarer and root once more before the result beat is
// loaded. The result sits in an output register, so the next polygon can
// start while it waits on out_stall. Both sums saturate.
// ----------------------------------------------------------------------------
module polygon_area_perimeter #(
  parameter int FRAC_BITS    = pap_pkg::FRAC_BITS_DEF,
  parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pap_pkg::COORD_W-1:0]   in_x_coord,
  input  logic signed [pap_pkg::COORD_W-1:0]   in_y_coord,
  input  logic                                 in_last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pap_pkg::AREA_W-1:0]    out_double_area,
  output logic        [pap_pkg::PERIM_W-1:0]   out_perimeter_fixed
);

  localparam int COORD_W = pap_pkg::COORD_W;
  localparam int DIFF_W  = pap_pkg::DIFF_W;
  localparam int PROD_W  = pap_pkg::PROD_W;
  localparam int AREA_W  = pap_pkg::AREA_W;
  localparam int PERIM_W = pap_pkg::PERIM_W;
  localparam int ROOT_W  = PROD_W / 2 + FRAC_BITS;
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);

  localparam logic [PERIM_W-1:0]       PERIM_MAX = {PERIM_W{1'b1}};
  localparam logic signed [AREA_W-1:0] AREA_MAX  = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic signed [AREA_W-1:0] AREA_MIN  = {1'b1, {(AREA_W-1){1'b0}}};

  pap_pkg::pap_state_t st_r, st_nxt;

  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      last_r;
  logic signed [AREA_W-1:0]  area_r;
  logic [PERIM_W-1:0]        perim_r;
  logic                      out_valid_r;
  logic signed [AREA_W-1:0]  out_area_r;
  logic [PERIM_W-1:0]        out_perim_r;

  logic accept, active, edge_go, out_free, mul_done;

  logic signed [DIFF_W-1:0] in_x_e, in_y_e, first_x_e, first_y_e, prev_x_e, prev_y_e;
  logic signed [DIFF_W-1:0] sq_dx, sq_dy;
  logic signed [DIFF_W-1:0] cr_a1, cr_b1, cr_a2, cr_b2;

  logic                     sq_start, sq_done, cr_done, rt_start, rt_done;
  logic signed [PROD_W-1:0] sq_prod, cr_prod;
  logic [ROOT_W-1:0]        rt_root;

  logic signed [AREA_W:0]   area_sum;
  logic signed [AREA_W-1:0] area_sat;
  logic [PERIM_W:0]         perim_sum;
  logic [PERIM_W-1:0]       perim_sat;

  // ---------------------------------------------------------------- operands
  always_comb begin
    in_x_e    = {in_x_coord[COORD_W-1], in_x_coord};
    in_y_e    = {in_y_coord[COORD_W-1], in_y_coord};
    first_x_e = {first_x_r[COORD_W-1], first_x_r};
    first_y_e = {first_y_r[COORD_W-1], first_y_r};
    prev_x_e  = {prev_x_r[COORD_W-1], prev_x_r};
    prev_y_e  = {prev_y_r[COORD_W-1], prev_y_r};

    if (st_r == pap_pkg::ST_CLOSE_START) begin
      sq_dx = first_x_e - prev_x_e;
      sq_dy = first_y_e - prev_y_e;
    end else begin
      sq_dx = in_x_e - prev_x_e;
      sq_dy = in_y_e - prev_y_e;
    end

    // (prev - first) x (cur - first), second term negated going in
    cr_a1 = prev_x_e - first_x_e;
    cr_b1 = in_y_e - first_y_e;
    cr_a2 = prev_y_e - first_y_e;
    cr_b2 = first_x_e - in_x_e;
  end

  assign in_stall = (st_r != pap_pkg::ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign active   = (cnt_r < CNT_W'(MAX_VERTICES));
  assign edge_go  = accept & active & (cnt_r != '0);
  assign out_free = ~out_valid_r | ~out_stall;
  assign mul_done = sq_done & cr_done;

  assign sq_start = edge_go | (st_r == pap_pkg::ST_CLOSE_START);
  assign rt_start = ((st_r == pap_pkg::ST_EDGE_MUL) & mul_done) |
                    ((st_r == pap_pkg::ST_CLOSE_MUL) & sq_done);

  // ---------------------------------------------------------------- units
  pap_mac #(.OP_W(DIFF_W)) u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a1    (sq_dx),
    .b1    (sq_dx),
    .a2    (sq_dy),
    .b2    (sq_dy),
    .done  (sq_done),
    .prod  (sq_prod)
  );

  pap_mac #(.OP_W(DIFF_W)) u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (edge_go),
    .a1    (cr_a1),
    .b1    (cr_b1),
    .a2    (cr_a2),
    .b2    (cr_b2),
    .done  (cr_done),
    .prod  (cr_prod)
  );

  pap_isqrt #(.IN_W(PROD_W), .FRAC_BITS(FRAC_BITS)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .n     ($unsigned(sq_prod)),
    .done  (rt_done),
    .root  (rt_root)
  );

  // ---------------------------------------------------------------- sums
  always_comb begin
    area_sum = {area_r[AREA_W-1], area_r} +
               {{(AREA_W+1-PROD_W){cr_prod[PROD_W-1]}}, cr_prod};
    if (area_sum[AREA_W] != area_sum[AREA_W-1]) begin
      area_sat = area_sum[AREA_W] ? AREA_MIN : AREA_MAX;
    end else begin
      area_sat = area_sum[AREA_W-1:0];
    end

    perim_sum = {1'b0, perim_r} + {{(PERIM_W+1-ROOT_W){1'b0}}, rt_root};
    perim_sat = (perim_sum >= {1'b0, PERIM_MAX}) ? PERIM_MAX : perim_sum[PERIM_W-1:0];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pap_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pap_pkg::ST_IDLE: begin
        if (edge_go) begin
          st_nxt = pap_pkg::ST_EDGE_MUL;
        end else if (accept & in_last_vertex) begin
          st_nxt = pap_pkg::ST_CLOSE_START;
        end
      end
      pap_pkg::ST_EDGE_MUL: begin
        if (mul_done) st_nxt = pap_pkg::ST_EDGE_ROOT;
      end
      pap_pkg::ST_EDGE_ROOT: begin
        if (rt_done) st_nxt = last_r ? pap_pkg::ST_CLOSE_START : pap_pkg::ST_IDLE;
      end
      pap_pkg::ST_CLOSE_START: begin
        st_nxt = pap_pkg::ST_CLOSE_MUL;
      end
      pap_pkg::ST_CLOSE_MUL: begin
        if (sq_done) st_nxt = pap_pkg::ST_CLOSE_ROOT;
      end
      pap_pkg::ST_CLOSE_ROOT: begin
        if (rt_done) st_nxt = pap_pkg::ST_DONE;
      end
      pap_pkg::ST_DONE: begin
        if (out_free) st_nxt = pap_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = pap_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      area_r      <= '0;
      perim_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept & active & (cnt_r == '0)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if ((st_r == pap_pkg::ST_EDGE_MUL) & mul_done) begin
        area_r <= area_sat;
      end
      if ((st_r == pap_pkg::ST_EDGE_ROOT) & rt_done) begin
        perim_r <= perim_sat;
        cnt_r   <= cnt_r + CNT_W'(1);
      end
      if ((st_r == pap_pkg::ST_CLOSE_ROOT) & rt_done) begin
        perim_r <= perim_sat;
      end

      if ((st_r == pap_pkg::ST_DONE) & out_free) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        area_r      <= '0;
        perim_r     <= '0;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last_vertex;
    end
    if (accept & active & (cnt_r == '0)) begin
      first_x_r <= in_x_coord;
      first_y_r <= in_y_coord;
      prev_x_r  <= in_x_coord;
      prev_y_r  <= in_y_coord;
    end
    if (edge_go) begin
      cur_x_r <= in_x_coord;
      cur_y_r <= in_y_coord;
    end
    if ((st_r == pap_pkg::ST_EDGE_ROOT) & rt_done) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if ((st_r == pap_pkg::ST_DONE) & out_free) begin
      out_area_r  <= area_r;
      out_perim_r <= perim_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_double_area     = out_area_r;
  assign out_perimeter_fixed = out_perim_r;

endmodule

// ----- hw/rtl/pap_mac.sv -----
// ----------------------------------------------------------------------------
// pap_mac
// Bit-serial signed multiply-accumulate: prod = a1*b1 + a2*b2, one multiplier
// bit of each product per cycle.
// ----------------------------------------------------------------------------
module pap_mac #(
  parameter int OP_W = pap_pkg::DIFF_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [OP_W-1:0]   a1,
  input  logic signed [OP_W-1:0]   b1,
  input  logic signed [OP_W-1:0]   a2,
  input  logic signed [OP_W-1:0]   b2,
  output logic                     done,
  output logic signed [2*OP_W-1:0] prod
);

  localparam int ACC_W = 2 * OP_W;
  localparam int CNT_W = $clog2(OP_W);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [ACC_W-1:0] mc1_r, mc2_r;
  logic [OP_W-1:0]         mp1_r, mp2_r;
  logic signed [ACC_W-1:0] acc_r;

  logic                    step_last;
  logic signed [ACC_W-1:0] t1, t2, tsum, acc_nxt;

  always_comb begin
    step_last = (cnt_r == CNT_W'(OP_W - 1));
    t1        = mp1_r[0] ? mc1_r : '0;
    t2        = mp2_r[0] ? mc2_r : '0;
    tsum      = t1 + t2;
    // multiplier MSB carries negative weight
    acc_nxt   = step_last ? (acc_r - tsum) : (acc_r + tsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & step_last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (step_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc1_r <= {{OP_W{a1[OP_W-1]}}, a1};
      mc2_r <= {{OP_W{a2[OP_W-1]}}, a2};
      mp1_r <= b1;
      mp2_r <= b2;
      acc_r <= '0;
    end else if (busy_r) begin
      mc1_r <= mc1_r << 1;
      mc2_r <= mc2_r << 1;
      mp1_r <= mp1_r >> 1;
      mp2_r <= mp2_r >> 1;
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- hw/rtl/pap_isqrt.sv -----
// ----------------------------------------------------------------------------
// pap_isqrt
// Digit-serial integer square root: root = floor(sqrt(n * 4^FRAC_BITS)),
// one result bit (one base-4 digit of n) per cycle.
// ----------------------------------------------------------------------------
module pap_isqrt #(
  parameter  int IN_W      = pap_pkg::PROD_W,
  parameter  int FRAC_BITS = pap_pkg::FRAC_BITS_DEF,
  localparam int ROOT_W    = IN_W / 2 + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IN_W-1:0]   n,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IN_W-1:0]   nsh_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;

  logic              step_last;
  logic [ROOT_W+3:0] rem_cat, trial, diff;
  logic              ge;
  logic [ROOT_W+1:0] rem_nxt;

  always_comb begin
    step_last = (cnt_r == CNT_W'(ROOT_W - 1));
    // fraction steps see zeros once n is shifted out
    rem_cat   = {rem_r, nsh_r[IN_W-1 -: 2]};
    trial     = {2'b00, root_r, 2'b01};
    ge        = (rem_cat >= trial);
    diff      = rem_cat - trial;
    rem_nxt   = ge ? diff[ROOT_W+1:0] : rem_cat[ROOT_W+1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & step_last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (step_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r  <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      nsh_r  <= {nsh_r[IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hw/rtl/pap_checker.sv -----
// ----------------------------------------------------------------------------
// pap_checker
// Port-level checks for polygon_area_perimeter, bound to the top level.
// ----------------------------------------------------------------------------
module pap_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic signed [pap_pkg::COORD_W-1:0]   in_x_coord,
  input logic signed [pap_pkg::COORD_W-1:0]   in_y_coord,
  input logic                                 in_last_vertex,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [pap_pkg::AREA_W-1:0]    out_double_area,
  input logic        [pap_pkg::PERIM_W-1:0]   out_perimeter_fixed
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_double_area) &&
                               $stable(out_perimeter_fixed))
    else $error("result beat changed while stalled");

  // closing a polygon always takes more than the accept cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_vertex |=> in_stall)
    else $error("input not stalled after last vertex");

  // a new result is loaded from the busy closing pass, which then frees the input
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result loaded outside closing pass");

  // zero perimeter means a degenerate polygon, so the area is zero too
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_perimeter_fixed == '0) |-> (out_double_area == '0))
    else $error("nonzero area with zero perimeter");

endmodule

bind polygon_area_perimeter pap_checker u_pap_checker (.*);

// ----- sim/tb_polygon_area_perimeter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_area_perimeter
// Streams polygons into the shoelace area / perimeter block and checks every
// result beat against a cycle-free predictor kept in step with the accepted
// vertex beats. Covers extreme coordinates, one- and two-vertex polygons,
// both orientations, random polygons under random idling, a long output
// hold-off that fills the block, and a polygon past the vertex limit.
// ----------------------------------------------------------------------------
module tb_polygon_area_perimeter;

  localparam int COORD_W      = pap_pkg::COORD_W;
  localparam int AREA_W       = pap_pkg::AREA_W;
  localparam int PERIM_W      = pap_pkg::PERIM_W;
  localparam int FRAC         = pap_pkg::FRAC_BITS_DEF;
  localparam int VERTEX_MAX   = pap_pkg::MAX_VERTICES_DEF;
  localparam int HOLD_CYCLES  = 1000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic signed [AREA_W-1:0] double_area;
    logic        [PERIM_W-1:0] perimeter;
  } polygon_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_x_coord;
  logic signed [COORD_W-1:0] in_y_coord;
  logic                      in_last_vertex;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [AREA_W-1:0]  out_double_area;
  logic        [PERIM_W-1:0] out_perimeter_fixed;

  // predictor state for the polygon being streamed
  longint          first_x, first_y, prev_x, prev_y;
  int              vertex_count;
  longint          area2_acc;
  longint unsigned perim_acc;
  polygon_result_t closed_polygons[$];

  int   mismatches;
  int   cycle_count;
  bit   src_idle;
  bit   sink_idle;
  bit   long_hold;

  polygon_area_perimeter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_x_coord          (in_x_coord),
    .in_y_coord          (in_y_coord),
    .in_last_vertex      (in_last_vertex),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_double_area     (out_double_area),
    .out_perimeter_fixed (out_perimeter_fixed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL polygon_area_perimeter");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // truncated sqrt of (dx^2 + dy^2) scaled by 4^FRAC, two bits per round
  function automatic longint unsigned edge_length_fixed(longint dx, longint dy);
    longint unsigned sq, root, rem, trial;
    int i;
    sq = longint'(dx * dx + dy * dy);
    sq = sq << (2 * FRAC);
    root = 0;
    rem = 0;
    for (i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((sq >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic void add_edge(longint unsigned len);
    longint unsigned lim;
    lim = (64'd1 << PERIM_W) - 1;
    if (len >= lim || perim_acc >= lim - len) perim_acc = lim;
    else perim_acc = perim_acc + len;
  endfunction

  function automatic void add_cross(longint c);
    longint hi, lo;
    hi = (64'sd1 <<< (AREA_W - 1)) - 1;
    lo = -hi - 1;
    area2_acc = area2_acc + c;
    if (area2_acc > hi) area2_acc = hi;
    if (area2_acc < lo) area2_acc = lo;
  endfunction

  function automatic void clear_polygon();
    first_x = 0;
    first_y = 0;
    prev_x = 0;
    prev_y = 0;
    vertex_count = 0;
    area2_acc = 0;
    perim_acc = 0;
  endfunction

  // fold one accepted vertex into the running sums; closing vertex queues a result
  function automatic void fold_vertex(logic signed [COORD_W-1:0] x_in,
                                      logic signed [COORD_W-1:0] y_in,
                                      logic last);
    longint x, y;
    polygon_result_t res;
    x = longint'(x_in);
    y = longint'(y_in);
    if (vertex_count < VERTEX_MAX) begin
      if (vertex_count == 0) begin
        first_x = x;
        first_y = y;
      end else begin
        add_edge(edge_length_fixed(x - prev_x, y - prev_y));
        if (vertex_count >= 2)
          add_cross((prev_x - first_x) * (y - first_y) - (prev_y - first_y) * (x - first_x));
      end
      prev_x = x;
      prev_y = y;
      vertex_count++;
    end
    if (last) begin
      add_edge(edge_length_fixed(first_x - prev_x, first_y - prev_y));
      res.double_area = area2_acc[AREA_W-1:0];
      res.perimeter = perim_acc[PERIM_W-1:0];
      closed_polygons.push_back(res);
      clear_polygon();
    end
  endfunction

  // one vertex beat; returns at the edge where it is taken
  task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic last);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_x_coord <= COORD_W'($urandom);
      in_y_coord <= COORD_W'($urandom);
      in_last_vertex <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_vertex(x, y, last);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(int span);
    if (span >= 32768) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_polygon(input int n_vert, input int span);
    int k;
    for (k = 0; k < n_vert; k++)
      send_vertex(pick_coord(span), pick_coord(span), k == n_vert - 1);
  endtask

  // result side: random stall before each beat, one long hold-off on request
  initial begin : result_sink
    int wait_n;
    out_stall = 1'b0;
    forever begin
      wait_n = sink_idle ? $urandom_range(0, 5) : 0;
      if (long_hold) begin
        wait_n = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      repeat (wait_n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    polygon_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (closed_polygons.size() == 0) begin
        report_mismatch($sformatf("result beat with no polygon pending: area %0d perim %0d",
                                  out_double_area, out_perimeter_fixed));
      end else begin
        want = closed_polygons.pop_front();
        if (out_double_area !== want.double_area)
          report_mismatch($sformatf("double_area %0d, want %0d",
                                    out_double_area, want.double_area));
        if (out_perimeter_fixed !== want.perimeter)
          report_mismatch($sformatf("perimeter_fixed %0d, want %0d",
                                    out_perimeter_fixed, want.perimeter));
      end
    end
  end

  task automatic test_directed_shapes();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    // single vertex: both outputs zero
    send_vertex(16'sd0, 16'sd0, 1'b1);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    // two vertices across the full range: perimeter is twice the edge
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b1);
    // full-range square, counterclockwise
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    // clockwise triangle gives a negative area
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd100, 1'b0);
    send_vertex(16'sd100, 16'sd0, 1'b1);
    // collinear points
    send_vertex(16'sd1, 16'sd1, 1'b0);
    send_vertex(16'sd2, 16'sd2, 1'b0);
    send_vertex(16'sd3, 16'sd3, 1'b1);
    // unit triangle: diagonal edge exercises the fraction bits
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 1'b1);
    // repeated vertex, zero-length edges
    send_vertex(-16'sd5, 16'sd7, 1'b0);
    send_vertex(-16'sd5, 16'sd7, 1'b1);
  endtask

  task automatic test_random_polygons();
    int sent;
    int n_vert;
    int span;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) n_vert = $urandom_range(1, 2);
      else if (pick < 95) n_vert = $urandom_range(3, 10);
      else n_vert = $urandom_range(40, 60);
      pick = $urandom_range(0, 9);
      span = (pick < 5) ? 32768 : (pick < 8) ? 1000 : 8;
      send_polygon(n_vert, span);
      sent += n_vert;
    end
  endtask

  // hold the result side long enough that finished polygons back up into the input
  task automatic test_output_backpressure();
    int k;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    long_hold = 1'b1;
    for (k = 0; k < 8; k++) send_polygon(3, 32768);
    sink_idle = 1'b1;
  endtask

  // vertices past the limit are dropped; the flag on a dropped beat still closes
  task automatic test_vertex_limit();
    src_idle = 1'b0;
    sink_idle = 1'b1;
    send_polygon(VERTEX_MAX + 6, 32768);
    src_idle = 1'b1;
    send_polygon(4, 1000);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_last_vertex = 1'b0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    long_hold = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    clear_polygon();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_shapes();
    test_random_polygons();
    test_output_backpressure();
    test_vertex_limit();

    @(negedge clk);
    in_valid <= 1'b0;
    while (closed_polygons.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS polygon_area_perimeter");
    end else begin
      $display("FAIL polygon_area_perimeter");
    end
    $finish;
  end

endmodule
